// ===== design/tudbs_pkg.sv =====
// ----------------------------------------------------------------------------
// tudbs_pkg
// Types and constants shared by the timed up/down bit sender.
// ----------------------------------------------------------------------------
package tudbs_pkg;

    localparam int unsigned MAX_BITS   = 64;
    localparam int unsigned SEQ_W      = 64;
    localparam int unsigned LEN_W      = 7;
    localparam int unsigned POS_W      = 7;
    localparam int unsigned IDX_W      = 6;
    localparam int unsigned DWELL_W    = 4;
    localparam int unsigned PHASE_W    = 3;
    localparam int unsigned PADDR_W    = 4;
    localparam int unsigned PDATA_W    = 64;

    localparam logic [DWELL_W-1:0] DWELL_MAX   = 4'd15;
    localparam logic [DWELL_W-1:0] DWELL_SHORT = 4'd2;
    localparam logic [DWELL_W-1:0] DWELL_LONG  = 4'd4;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    localparam logic REG_BIT_SEQUENCE = 1'b0;
    localparam logic REG_SEQ_LENGTH   = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic signed [31:0] start_value;
    } t_in_item;

    typedef struct packed {
        logic               up_pulse;
        logic               down_pulse;
        logic               tick_wanted;
        logic [PHASE_W-1:0] phase;
    } t_out_item;

endpackage

// ===== design/timed_up_down_bit_sender_core.sv =====
// ----------------------------------------------------------------------------
// timed_up_down_bit_sender_core
// Eight-phase sender that turns a configured bit sequence into timed up and
// down pulses, one result item for each start or tick item.
// ----------------------------------------------------------------------------
// Each item is captured in an input register and then resolved against the
// phase, dwell counter and read position, with the result held in an output
// register; one item is accepted every cycle while the output side does not
// stall, and each result leaves through the input and output registers. The
// sequence and its length are written over the APB port at byte addresses 0
// and 8 (64-bit data) and must only be changed while the block is idle.
module timed_up_down_bit_sender_core
    import tudbs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_item,

    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_item,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam logic [PHASE_W-1:0] PH_A = 3'd0;
    localparam logic [PHASE_W-1:0] PH_B = 3'd1;
    localparam logic [PHASE_W-1:0] PH_C = 3'd2;
    localparam logic [PHASE_W-1:0] PH_D = 3'd3;
    localparam logic [PHASE_W-1:0] PH_E = 3'd4;
    localparam logic [PHASE_W-1:0] PH_F = 3'd5;
    localparam logic [PHASE_W-1:0] PH_G = 3'd6;
    localparam logic [PHASE_W-1:0] PH_H = 3'd7;

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_BITS);

    logic [SEQ_W-1:0]   r_bit_sequence;
    logic [LEN_W-1:0]   r_seq_length;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [DWELL_W-1:0] r_dwell, n_dwell;
    logic [POS_W-1:0]   r_read_pos, n_read_pos;

    logic               r_in_valid;
    t_in_item           r_in_item;
    logic               r_out_valid;
    t_out_item          r_out_item, n_out_item;

    logic               advance;
    logic               cfg_write;
    logic [LEN_W-1:0]   eff_len;
    logic               seq_empty;
    logic               front;
    logic               consume;
    logic [DWELL_W-1:0] t_val;
    logic               up, down, want;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        if (paddr[3] == REG_SEQ_LENGTH) begin
            prdata = PDATA_W'(r_seq_length);
        end else begin
            prdata = r_bit_sequence;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_sequence <= '0;
            r_seq_length   <= '0;
        end else if (cfg_write) begin
            if (paddr[3] == REG_BIT_SEQUENCE) begin
                r_bit_sequence <= pwdata;
            end else begin
                r_seq_length <= pwdata[LEN_W-1:0];
            end
        end
    end

    // handshake
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // sequence front
    assign eff_len   = (r_seq_length > LEN_MAX) ? LEN_MAX : r_seq_length;
    assign seq_empty = (r_read_pos >= eff_len);
    assign front     = r_bit_sequence[r_read_pos[IDX_W-1:0]];

    always_comb begin
        n_phase = r_phase;
        n_dwell = r_dwell;
        consume = 1'b0;
        up      = 1'b0;
        down    = 1'b0;
        want    = 1'b0;
        t_val   = r_dwell;
        if (r_in_item.req_type == REQ_START) begin
            if (r_phase == PH_A && r_in_item.start_value == 32'sd1) begin
                consume = 1'b1;
                n_phase = PH_B;
                n_dwell = DWELL_W'(1);
                want    = 1'b1;
            end
        end else begin
            want = 1'b1;
            unique case (r_phase)
                PH_A: begin
                    want = 1'b0;
                end
                PH_B: begin
                    if (t_val >= DWELL_SHORT && !seq_empty) begin
                        up      = 1'b1;
                        consume = 1'b1;
                        n_phase = front ? PH_C : PH_D;
                        t_val   = '0;
                    end
                end
                PH_C: begin
                    if (r_dwell >= DWELL_SHORT) begin
                        down    = 1'b1;
                        n_phase = PH_B;
                        t_val   = '0;
                    end
                end
                PH_D: begin
                    if (r_dwell >= DWELL_LONG && !seq_empty) begin
                        down    = 1'b1;
                        consume = 1'b1;
                        n_phase = front ? PH_E : PH_F;
                        t_val   = '0;
                    end
                end
                PH_E: begin
                    if (r_dwell >= DWELL_LONG && !seq_empty) begin
                        up      = 1'b1;
                        consume = 1'b1;
                        n_phase = front ? PH_C : PH_D;
                        t_val   = '0;
                    end
                end
                PH_F: begin
                    if (r_dwell >= DWELL_SHORT) begin
                        up      = 1'b1;
                        n_phase = PH_G;
                        t_val   = '0;
                    end
                end
                PH_G: begin
                    if (r_dwell >= DWELL_SHORT) begin
                        down = 1'b1;
                        if (!seq_empty) begin
                            consume = 1'b1;
                            n_phase = front ? PH_E : PH_F;
                            t_val   = '0;
                        end else begin
                            n_phase = PH_H;
                        end
                    end
                end
                PH_H: begin
                    if (r_dwell >= DWELL_LONG) begin
                        n_phase = PH_A;
                        want    = 1'b0;
                    end
                end
                default: begin
                    want = 1'b0;
                end
            endcase
            n_dwell = (t_val == DWELL_MAX) ? DWELL_MAX : t_val + DWELL_W'(1);
        end
        n_read_pos = (consume && !seq_empty) ? r_read_pos + POS_W'(1) : r_read_pos;
        n_out_item.up_pulse    = up;
        n_out_item.down_pulse  = down;
        n_out_item.tick_wanted = want;
        n_out_item.phase       = n_phase;
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
    end

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_A;
            r_dwell     <= '0;
            r_read_pos  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_phase     <= n_phase;
                r_dwell     <= n_dwell;
                r_read_pos  <= n_read_pos;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= n_out_item;
        end
    end

endmodule
